// File: sv/prrts_pkg.sv
// package of types and constants for the task scheduler
`default_nettype none
package prrts_pkg;
    localparam int MAX_TASKS   = 16;
    localparam int QUEUE_DEPTH = 32;
    localparam int TID_W  = $clog2(MAX_TASKS);
    localparam int TCNT_W = $clog2(MAX_TASKS + 1);
    localparam int QP_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_CREATE    = 3'd0,
        CMD_ACTIVATE  = 3'd1,
        CMD_TERMINATE = 3'd2,
        CMD_WAIT      = 3'd3,
        CMD_TICK      = 3'd4,
        CMD_START     = 3'd5,
        CMD_PICK      = 3'd6,
        CMD_NONE      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_SUSPENDED = 2'd0,
        ST_WAITING   = 2'd1,
        ST_READY     = 2'd2,
        ST_RUNNING   = 2'd3
    } tstate_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_FULL    = 2'd1,
        ERR_UNKNOWN = 2'd2
    } err_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK,
        S_BEST,
        S_FILL,
        S_PICK_RD,
        S_PICK,
        S_DONE
    } seq_t;

    localparam logic [7:0] IDLE_PRIO = 8'd255;
endpackage
`default_nettype wire

// File: sv/prrts_ram.sv
// generic single-port ram with registered read
`default_nettype none
module prrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: sv/priority_round_robin_task_scheduler_core.sv
// top level of the fixed-priority round-robin task scheduler
//
// usage: drive command, task_id, priority_req and wait_ticks and pulse start
// while busy is low; the transaction is taken at that edge and busy rises.
// the block walks the task table one entry per cycle with a single shared
// compare unit: a tick visits every created task, a rebuild scans the table
// once for the best priority and once more to refill the ready queue.
// steps, from the accepting edge: create, unknown id, unused command and a
// stopped pick-next go from decode to done; a running pick-next reads the
// queue head and picks before done; activate, terminate, timed wait and start
// scan for the best priority and refill the queue, then pick when a switch
// follows; a tick scans the table and also rebuilds the queue when it releases a task.
// one transaction is in flight at a time; busy falls as done rises, so the
// next transaction can be taken at the edge that ends the done cycle.
// the result (task_id_out, switch_request, error, ready_count) is shown for
// one cycle with done high; the receiver cannot stall it.
// the ready queue sits in a ram; its contents are undefined after reset and
// only live slots between head and tail are ever read, so no clearing pass.
// reset: idle task 0 exists with priority 255, all tasks suspended,
// scheduler stopped, queue empty.
`default_nettype none
module priority_round_robin_task_scheduler_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [3:0]  task_id,
    input  wire logic [7:0]  priority_req,
    input  wire logic [15:0] wait_ticks,
    output logic             done,
    output logic [3:0]       task_id_out,
    output logic             switch_request,
    output logic [1:0]       error,
    output logic [5:0]       ready_count
);
    localparam int TW = prrts_pkg::TID_W;
    localparam int CW = prrts_pkg::TCNT_W;
    localparam int PW = prrts_pkg::QP_W;
    localparam int QW = prrts_pkg::QC_W;

    // task table in flip-flops, read through the scan index and the current and popped ids
    logic [7:0]            prio_reg  [prrts_pkg::MAX_TASKS];
    prrts_pkg::tstate_t    tstate_reg [prrts_pkg::MAX_TASKS];
    logic [15:0]           wcnt_reg  [prrts_pkg::MAX_TASKS];
    logic [prrts_pkg::MAX_TASKS-1:0] block_reg;

    logic [CW-1:0] tcount_reg;
    logic [PW-1:0] head_reg, tail_reg;
    logic [QW-1:0] qcount_reg;
    logic [TW-1:0] cur_reg, nxt_reg;
    logic          running_reg;

    prrts_pkg::seq_t state_reg, state_next;
    prrts_pkg::cmd_t cmd_reg;
    logic [TW-1:0]   tid_reg;
    logic [7:0]      preq_reg;
    logic [15:0]     ticks_reg;
    logic [CW-1:0]   idx_reg;
    logic [8:0]      best_reg;
    logic            rel_reg;
    logic            sw_reg;
    logic [1:0]      err_reg;
    logic [TW-1:0]   idout_reg;

    // queue ram port
    logic          q_we;
    logic [PW-1:0] q_addr;
    logic [TW-1:0] q_wdata, q_rdata;

    prrts_ram #(.WIDTH(TW), .DEPTH(prrts_pkg::QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .addr  (q_addr),
        .wdata (q_wdata),
        .rdata (q_rdata)
    );

    // scan index into the table
    logic [TW-1:0] idx;
    logic          idx_end;
    assign idx     = idx_reg[TW-1:0];
    assign idx_end = (idx_reg + CW'(1) >= tcount_reg);

    // shared compare unit: candidate priority versus best
    logic       live;
    logic [8:0] cand;
    logic       lt, eq;
    assign live = (tstate_reg[idx] != prrts_pkg::ST_SUSPENDED);
    assign cand = {1'b0, prio_reg[idx]};
    assign lt   = cand < best_reg;
    assign eq   = cand == best_reg;

    logic q_full, q_empty;
    assign q_full  = (qcount_reg == QW'(prrts_pkg::QUEUE_DEPTH));
    assign q_empty = (qcount_reg == '0);

    // pick-next decode against the popped id
    logic [TW-1:0] popped;
    logic          cur_live;
    assign popped   = q_rdata;
    assign cur_live = (tstate_reg[cur_reg] != prrts_pkg::ST_SUSPENDED);

    logic valid_tid;
    assign valid_tid = (CW'(tid_reg) < tcount_reg);

    logic pick_after;
    assign pick_after = running_reg && (cur_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prrts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = prrts_pkg::S_DECODE;
                end
            end
            prrts_pkg::S_DECODE:
            begin
                unique case (cmd_reg) inside
                    prrts_pkg::CMD_ACTIVATE, prrts_pkg::CMD_TERMINATE,
                    prrts_pkg::CMD_WAIT:
                        state_next = valid_tid ? prrts_pkg::S_BEST : prrts_pkg::S_DONE;
                    prrts_pkg::CMD_TICK:  state_next = prrts_pkg::S_TICK;
                    prrts_pkg::CMD_START: state_next = prrts_pkg::S_BEST;
                    prrts_pkg::CMD_PICK:
                        state_next = running_reg ? prrts_pkg::S_PICK_RD : prrts_pkg::S_DONE;
                    default: state_next = prrts_pkg::S_DONE;
                endcase
            end
            prrts_pkg::S_TICK:
            begin
                if (idx_end)
                begin
                    state_next = (rel_reg || (tstate_reg[idx] == prrts_pkg::ST_SUSPENDED
                                  && block_reg[idx] && wcnt_reg[idx] <= 16'd1))
                                 ? prrts_pkg::S_BEST : prrts_pkg::S_DONE;
                end
            end
            prrts_pkg::S_BEST:
            begin
                if (idx_end)
                begin
                    state_next = prrts_pkg::S_FILL;
                end
            end
            prrts_pkg::S_FILL:
            begin
                if (idx_end)
                begin
                    state_next = ((cmd_reg == prrts_pkg::CMD_ACTIVATE ||
                                   cmd_reg == prrts_pkg::CMD_TERMINATE ||
                                   cmd_reg == prrts_pkg::CMD_WAIT) && pick_after)
                                 ? prrts_pkg::S_PICK_RD : prrts_pkg::S_DONE;
                end
            end
            prrts_pkg::S_PICK_RD: state_next = prrts_pkg::S_PICK;
            prrts_pkg::S_PICK:    state_next = prrts_pkg::S_DONE;
            prrts_pkg::S_DONE:    state_next = prrts_pkg::S_IDLE;
            default:              state_next = prrts_pkg::S_IDLE;
        endcase
    end

    // queue ram control
    always_comb
    begin
        q_we    = 1'b0;
        q_addr  = head_reg;
        q_wdata = idx;
        unique case (state_reg)
            prrts_pkg::S_FILL:
            begin
                q_addr  = tail_reg;
                q_wdata = idx;
                q_we    = live && eq && !q_full;
            end
            prrts_pkg::S_PICK:
            begin
                q_addr  = tail_reg;
                q_wdata = cur_reg;
                if (q_empty)
                begin
                    q_we = cur_live;
                end
                else
                begin
                    // after pop one slot is free
                    q_we = cur_live && (prio_reg[cur_reg] == prio_reg[popped]);
                end
            end
            default:
            begin
                q_we = 1'b0;
            end
        endcase
    end

    logic [PW-1:0] tail_inc, head_inc;
    assign tail_inc = (tail_reg == PW'(prrts_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_reg + PW'(1);
    assign head_inc = (head_reg == PW'(prrts_pkg::QUEUE_DEPTH - 1)) ? '0 : head_reg + PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= prrts_pkg::S_IDLE;
            tcount_reg  <= CW'(1);
            head_reg    <= '0;
            tail_reg    <= '0;
            qcount_reg  <= '0;
            cur_reg     <= '0;
            nxt_reg     <= '0;
            running_reg <= 1'b0;
            block_reg   <= '0;
            idx_reg     <= '0;
            rel_reg     <= 1'b0;
            sw_reg      <= 1'b0;
            err_reg     <= prrts_pkg::ERR_OK;
            done        <= 1'b0;
            cmd_reg     <= prrts_pkg::CMD_NONE;
            tid_reg     <= '0;
            preq_reg    <= '0;
            ticks_reg   <= '0;
            best_reg    <= 9'd256;
            idout_reg   <= '0;
            for (int i = 0; i < prrts_pkg::MAX_TASKS; i++)
            begin
                tstate_reg[i] <= prrts_pkg::ST_SUSPENDED;
                wcnt_reg[i]   <= '0;
                prio_reg[i]   <= (i == 0) ? prrts_pkg::IDLE_PRIO : 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == prrts_pkg::S_DONE);
            unique case (state_reg)
                prrts_pkg::S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= prrts_pkg::cmd_t'(command);
                        tid_reg   <= task_id;
                        preq_reg  <= priority_req;
                        ticks_reg <= wait_ticks;
                        sw_reg    <= 1'b0;
                        err_reg   <= prrts_pkg::ERR_OK;
                        rel_reg   <= 1'b0;
                        idx_reg   <= '0;
                        best_reg  <= 9'd256;
                    end
                end
                prrts_pkg::S_DECODE:
                begin
                    // non-create results pick up next task in the done step
                    unique case (cmd_reg) inside
                        prrts_pkg::CMD_CREATE:
                        begin
                            if (tcount_reg >= CW'(prrts_pkg::MAX_TASKS))
                            begin
                                err_reg   <= prrts_pkg::ERR_FULL;
                                idout_reg <= '0;
                            end
                            else
                            begin
                                idout_reg <= tcount_reg[TW-1:0];
                                prio_reg[tcount_reg[TW-1:0]]   <= preq_reg;
                                tstate_reg[tcount_reg[TW-1:0]] <= prrts_pkg::ST_SUSPENDED;
                                wcnt_reg[tcount_reg[TW-1:0]]   <= '0;
                                block_reg[tcount_reg[TW-1:0]]  <= 1'b0;
                                tcount_reg <= tcount_reg + CW'(1);
                            end
                        end
                        prrts_pkg::CMD_ACTIVATE, prrts_pkg::CMD_TERMINATE,
                        prrts_pkg::CMD_WAIT:
                        begin
                            if (!valid_tid)
                            begin
                                err_reg <= prrts_pkg::ERR_UNKNOWN;
                            end
                            else if (cmd_reg == prrts_pkg::CMD_ACTIVATE)
                            begin
                                tstate_reg[tid_reg] <= prrts_pkg::ST_WAITING;
                            end
                            else
                            begin
                                tstate_reg[tid_reg] <= prrts_pkg::ST_SUSPENDED;
                                if (cmd_reg == prrts_pkg::CMD_WAIT)
                                begin
                                    block_reg[tid_reg] <= 1'b1;
                                    wcnt_reg[tid_reg]  <= ticks_reg;
                                end
                            end
                        end
                        prrts_pkg::CMD_START:
                        begin
                            running_reg   <= 1'b1;
                            cur_reg       <= '0;
                            tstate_reg[0] <= prrts_pkg::ST_WAITING;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                prrts_pkg::S_TICK:
                begin
                    if (tstate_reg[idx] == prrts_pkg::ST_SUSPENDED && block_reg[idx])
                    begin
                        if (wcnt_reg[idx] <= 16'd1)
                        begin
                            wcnt_reg[idx]   <= '0;
                            tstate_reg[idx] <= prrts_pkg::ST_WAITING;
                            block_reg[idx]  <= 1'b0;
                            rel_reg         <= 1'b1;
                        end
                        else
                        begin
                            wcnt_reg[idx] <= wcnt_reg[idx] - 16'd1;
                        end
                    end
                    idx_reg <= idx_end ? '0 : idx_reg + CW'(1);
                end
                prrts_pkg::S_BEST:
                begin
                    if (live && lt)
                    begin
                        best_reg <= cand;
                    end
                    idx_reg <= idx_end ? '0 : idx_reg + CW'(1);
                    if (idx_end)
                    begin
                        head_reg   <= '0;
                        tail_reg   <= '0;
                        qcount_reg <= '0;
                    end
                end
                prrts_pkg::S_FILL:
                begin
                    if (live && eq)
                    begin
                        tstate_reg[idx] <= prrts_pkg::ST_READY;
                        if (!q_full)
                        begin
                            tail_reg   <= tail_inc;
                            qcount_reg <= qcount_reg + QW'(1);
                        end
                    end
                    idx_reg <= idx_end ? '0 : idx_reg + CW'(1);
                end
                prrts_pkg::S_PICK:
                begin
                    sw_reg <= 1'b1;
                    if (q_empty)
                    begin
                        if (cur_live)
                        begin
                            tstate_reg[cur_reg] <= prrts_pkg::ST_RUNNING;
                            tail_reg   <= tail_inc;
                            qcount_reg <= qcount_reg + QW'(1);
                            nxt_reg    <= cur_reg;
                            cur_reg    <= cur_reg;
                            idout_reg  <= cur_reg;
                        end
                        else
                        begin
                            nxt_reg   <= '0;
                            cur_reg   <= '0;
                            idout_reg <= '0;
                        end
                    end
                    else
                    begin
                        nxt_reg   <= popped;
                        cur_reg   <= popped;
                        idout_reg <= popped;
                        head_reg  <= head_inc;
                        tstate_reg[popped] <= prrts_pkg::ST_RUNNING;
                        if (cur_live && (prio_reg[cur_reg] == prio_reg[popped]))
                        begin
                            tail_reg <= tail_inc;
                            if (cur_reg != popped)
                            begin
                                tstate_reg[cur_reg] <= prrts_pkg::ST_READY;
                            end
                        end
                        else
                        begin
                            qcount_reg <= qcount_reg - QW'(1);
                        end
                    end
                end
                prrts_pkg::S_DONE:
                begin
                    if (cmd_reg != prrts_pkg::CMD_CREATE && !sw_reg)
                    begin
                        idout_reg <= nxt_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign busy           = (state_reg != prrts_pkg::S_IDLE);
    assign task_id_out    = idout_reg;
    assign switch_request = sw_reg;
    assign error          = err_reg;
    assign ready_count    = 6'(qcount_reg);

    // queue count never exceeds its depth
    a_qcount: assert property (@(posedge clk) disable iff (!rst_n)
        qcount_reg <= QW'(prrts_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");
    // task count stays within table
    a_tcount: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg >= CW'(1) && tcount_reg <= CW'(prrts_pkg::MAX_TASKS))
        else $error("task count out of range");
    // a switch is only reported while the scheduler runs
    a_sw: assert property (@(posedge clk) disable iff (!rst_n)
        done && switch_request |-> running_reg)
        else $error("switch while stopped");
    // done follows the final sequencer step
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == prrts_pkg::S_DONE)
        else $error("stray done");
endmodule
`default_nettype wire
